[hw/rtl/contiguous_block_allocator_defines.svh]
// Assertion macros shared by the allocator RTL
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH

// Clocked implication check, disabled while the active-low reset is asserted
`define CBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked next-cycle implication check
`define CBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cba_pkg.sv]
package cba_pkg;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_MARK   = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] CFG_INT_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_EXT_CONNECTED = 3'd1;
  localparam logic [2:0] CFG_INT_SHIFT     = 3'd2;
  localparam logic [2:0] CFG_EXT_SHIFT     = 3'd3;
  localparam logic [2:0] CFG_INT_BASE      = 3'd4;
  localparam logic [2:0] CFG_INT_LAST      = 3'd5;
  localparam logic [2:0] CFG_EXT_BASE      = 3'd6;
  localparam logic [2:0] CFG_EXT_LAST      = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN,
    ST_COMMIT,
    ST_RANGE_RD,
    ST_RANGE_WR,
    ST_DONE
  } state_t;

  // Memory access request from the controller to one bit-map memory
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic        wr_val;
  } mem_ctl_t;

endpackage

[hw/rtl/cba_bitmap.sv]
module cba_bitmap #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  cba_pkg::mem_ctl_t    ctl,
  input  logic [AW-1:0]        addr,
  output logic                 rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= ctl.wr_val;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/contiguous_block_allocator.sv]
// Contiguous block allocator: first-fit allocation over an internal and an
// external occupancy bitmap, each held in a one-bit-wide synchronous memory.
// Input stream (in_*): one request item per handshake. tdata packs req_type,
// size_bytes, pool_sel, start_block, block_count from bit 0 up.
// Output stream (out_*): one result item per request, tdata packs block_addr,
// alloc_ok, free_int_blocks, free_ext_blocks from bit 0 up.
// Config port (cfg_*): register index and data, written while idle by the user;
// the block does not enforce this. An allocate walks the memory one bit at a
// time, reading then checking each bit scanned in each pool, and then reads and
// sets each committed bit. A range request reads then updates each bit in range,
// clipped to the map.
// One item is worked at a time; in_tready is low while busy.
// Reset: both memories are cleared by a pass over max(INT_BLOCKS,EXT_BLOCKS)
// entries, one entry per cycle in each; no item is accepted until it ends.
// Stall: a result waits in its output register until out_tready; the next
// request is accepted and worked meanwhile, and its result waits for the slot.
`include "contiguous_block_allocator_defines.svh"

module contiguous_block_allocator #(
  parameter int INT_BLOCKS   = 256,
  parameter int EXT_BLOCKS   = 4096,
  parameter int EXT_FLAG_BIT = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[1:0], size_bytes[33:2], pool_sel[34], start_block[46:35],
  // block_count[62:47]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // block_addr[15:0], alloc_ok[16], free_int_blocks[25:17],
  // free_ext_blocks[38:26]
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int IAW = $clog2(INT_BLOCKS);
  localparam int EAW = $clog2(EXT_BLOCKS);
  localparam int MAW = (IAW > EAW) ? IAW : EAW;
  localparam int CW  = MAW + 1;

  // configuration
  logic        int_enable_r, ext_connected_r;
  logic [4:0]  int_shift_r, ext_shift_r;
  logic [14:0] int_base_r, int_last_r, ext_base_r, ext_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_enable_r    <= 1'b1;
      ext_connected_r <= 1'b0;
      int_shift_r     <= 5'd8;
      ext_shift_r     <= 5'd12;
      int_base_r      <= '0;
      int_last_r      <= 15'h7FFF;
      ext_base_r      <= '0;
      ext_last_r      <= 15'h7FFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cba_pkg::CFG_INT_ENABLE:    int_enable_r    <= cfg_data[0];
        cba_pkg::CFG_EXT_CONNECTED: ext_connected_r <= cfg_data[0];
        cba_pkg::CFG_INT_SHIFT:     int_shift_r     <= cfg_data[4:0];
        cba_pkg::CFG_EXT_SHIFT:     ext_shift_r     <= cfg_data[4:0];
        cba_pkg::CFG_INT_BASE:      int_base_r      <= cfg_data;
        cba_pkg::CFG_INT_LAST:      int_last_r      <= cfg_data;
        cba_pkg::CFG_EXT_BASE:      ext_base_r      <= cfg_data;
        cba_pkg::CFG_EXT_LAST:      ext_last_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // request fields
  logic [1:0]  in_req;
  logic [31:0] in_size;
  logic        in_sel;
  logic [11:0] in_start;
  logic [15:0] in_count;
  assign in_req   = in_tdata[1:0];
  assign in_size  = in_tdata[33:2];
  assign in_sel   = in_tdata[34];
  assign in_start = in_tdata[46:35];
  assign in_count = in_tdata[62:47];

  cba_pkg::state_t state_r, state_nxt;
  logic        pool_r, pool_nxt;             // 1 = external
  logic [1:0]  req_r, req_nxt;
  logic [31:0] size_r, size_nxt;
  logic [MAW:0]  idx_r, idx_nxt;             // walk position
  logic [MAW:0]  run_r, run_nxt;
  logic [MAW:0]  rstart_r, rstart_nxt;
  logic [MAW:0]  need_r, need_nxt;
  logic [16:0]   rend_r, rend_nxt;            // exclusive range end
  logic          setv_r, setv_nxt;
  logic [12:0]   ifree_r, ifree_nxt;
  logic [14:0]   efree_r, efree_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic          ok_r, ok_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [39:0]   odata_r, odata_nxt;

  cba_pkg::mem_ctl_t ictl, ectl;
  logic [IAW-1:0] iaddr;
  logic [EAW-1:0] eaddr;
  logic irdata, erdata, rdbit;

  cba_bitmap #(.DEPTH(INT_BLOCKS), .AW(IAW)) u_int_map (
    .clk(clk), .ctl(ictl), .addr(iaddr), .rd_data(irdata));
  cba_bitmap #(.DEPTH(EXT_BLOCKS), .AW(EAW)) u_ext_map (
    .clk(clk), .ctl(ectl), .addr(eaddr), .rd_data(erdata));

  assign rdbit = pool_r ? erdata : irdata;

  logic [MAW:0] psize;
  assign psize = pool_r ? (CW)'(EXT_BLOCKS) : (CW)'(INT_BLOCKS);

  // blocks needed for a pool: (size >> shift) + 1, saturated past the pool
  function automatic logic [MAW:0] need_of(input logic [31:0] sz, input logic [4:0] sh,
                                           input logic [MAW:0] lim);
    logic [32:0] n;
    n = {1'b0, sz >> sh} + 33'd1;
    if (n > {{(33-CW){1'b0}}, lim}) begin
      return lim + (CW)'(1);
    end
    return n[MAW:0];
  endfunction

  logic [15:0] abs_addr;
  logic [15:0] flag_bit;
  assign flag_bit = 16'(1) << EXT_FLAG_BIT;
  assign abs_addr = pool_r ? ({1'b0, ext_base_r} + 16'(rstart_r))
                           : ({1'b0, int_base_r} + 16'(rstart_r));

  logic [14:0] plast;
  assign plast = pool_r ? ext_last_r : int_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cba_pkg::ST_CLEAR;
      idx_r    <= '0;
      ifree_r  <= 13'(INT_BLOCKS);
      efree_r  <= 15'(EXT_BLOCKS);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ifree_r  <= ifree_nxt;
      efree_r  <= efree_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pool_r   <= pool_nxt;
    req_r    <= req_nxt;
    size_r   <= size_nxt;
    run_r    <= run_nxt;
    rstart_r <= rstart_nxt;
    need_r   <= need_nxt;
    rend_r   <= rend_nxt;
    setv_r   <= setv_nxt;
    addr_r   <= addr_nxt;
    ok_r     <= ok_nxt;
    odata_r  <= odata_nxt;
  end

  // next-state logic: clear, accept, scan, commit, range walk; a failed pool tries the external pool or gives up
  always_comb begin
    state_nxt  = state_r;
    pool_nxt   = pool_r;
    req_nxt    = req_r;
    size_nxt   = size_r;
    idx_nxt    = idx_r;
    run_nxt    = run_r;
    rstart_nxt = rstart_r;
    need_nxt   = need_r;
    rend_nxt   = rend_r;
    setv_nxt   = setv_r;
    ifree_nxt  = ifree_r;
    efree_nxt  = efree_r;
    addr_nxt   = addr_r;
    ok_nxt     = ok_r;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ictl       = '0;
    ectl       = '0;
    iaddr      = idx_r[IAW-1:0];
    eaddr      = idx_r[EAW-1:0];
    in_tready  = 1'b0;

    unique case (state_r)
      cba_pkg::ST_CLEAR: begin
        ictl.wr_en = idx_r < (CW)'(INT_BLOCKS);
        ectl.wr_en = idx_r < (CW)'(EXT_BLOCKS);
        idx_nxt = idx_r + (CW)'(1);
        if (!ictl.wr_en && !ectl.wr_en) begin
          idx_nxt   = '0;
          state_nxt = cba_pkg::ST_IDLE;
        end
      end
      cba_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          req_nxt  = in_req;
          size_nxt = in_size;
          addr_nxt = '0;
          ok_nxt   = 1'b0;
          idx_nxt  = '0;
          run_nxt  = '0;
          unique case (in_req)
            cba_pkg::REQ_ALLOC: begin
              if (int_enable_r) begin
                pool_nxt  = 1'b0;
                need_nxt  = need_of(in_size, int_shift_r, (CW)'(INT_BLOCKS));
                state_nxt = cba_pkg::ST_SCAN_RD;
              end else if (ext_connected_r) begin
                pool_nxt  = 1'b1;
                need_nxt  = need_of(in_size, ext_shift_r, (CW)'(EXT_BLOCKS));
                state_nxt = cba_pkg::ST_SCAN_RD;
              end else begin
                state_nxt = cba_pkg::ST_DONE;
              end
            end
            cba_pkg::REQ_MARK, cba_pkg::REQ_FREE: begin
              pool_nxt  = (in_req == cba_pkg::REQ_FREE) ? 1'b1 : in_sel;
              setv_nxt  = (in_req == cba_pkg::REQ_MARK);
              idx_nxt   = (CW)'(in_start);
              rend_nxt  = 17'(in_start) + 17'(in_count);
              state_nxt = cba_pkg::ST_RANGE_RD;
            end
            default: state_nxt = cba_pkg::ST_DONE;
          endcase
        end
      end
      cba_pkg::ST_SCAN_RD: begin
        if (need_r > psize || idx_r >= psize) begin
          if (!pool_r && ext_connected_r) begin
            pool_nxt  = 1'b1;
            need_nxt  = need_of(size_r, ext_shift_r, (CW)'(EXT_BLOCKS));
            idx_nxt   = '0;
            run_nxt   = '0;
          end else begin
            state_nxt = cba_pkg::ST_DONE;
          end
        end else begin
          ictl.rd_en = !pool_r;
          ectl.rd_en = pool_r;
          state_nxt  = cba_pkg::ST_SCAN;
        end
      end
      cba_pkg::ST_SCAN: begin
        idx_nxt   = idx_r + (CW)'(1);
        state_nxt = cba_pkg::ST_SCAN_RD;
        if (!rdbit) begin
          if (run_r == '0) begin
            rstart_nxt = idx_r;
          end
          run_nxt = run_r + (CW)'(1);
          if (run_r + (CW)'(1) == need_r) begin
            if (run_r == '0) begin
              rstart_nxt = idx_r;
            end
            state_nxt = cba_pkg::ST_COMMIT;
          end
        end else begin
          run_nxt = '0;
        end
      end
      cba_pkg::ST_COMMIT: begin
        // the run is known free; check address bound then set its bits
        if ({1'b0, abs_addr[14:0]} > {1'b0, plast} || abs_addr[15]) begin
          if (!pool_r && ext_connected_r) begin
            pool_nxt  = 1'b1;
            need_nxt  = need_of(size_r, ext_shift_r, (CW)'(EXT_BLOCKS));
            idx_nxt   = '0;
            run_nxt   = '0;
            state_nxt = cba_pkg::ST_SCAN_RD;
          end else begin
            state_nxt = cba_pkg::ST_DONE;
          end
        end else begin
          addr_nxt  = pool_r ? (abs_addr | flag_bit) : abs_addr;
          ok_nxt    = 1'b1;
          setv_nxt  = 1'b1;
          idx_nxt   = rstart_r;
          rend_nxt  = 17'(rstart_r) + 17'(need_r);
          state_nxt = cba_pkg::ST_RANGE_RD;
        end
      end
      cba_pkg::ST_RANGE_RD: begin
        if (17'(idx_r) >= rend_r || idx_r >= psize) begin
          state_nxt = cba_pkg::ST_DONE;
        end else begin
          ictl.rd_en = !pool_r;
          ectl.rd_en = pool_r;
          state_nxt  = cba_pkg::ST_RANGE_WR;
        end
      end
      cba_pkg::ST_RANGE_WR: begin
        if (rdbit != setv_r) begin
          ictl.wr_en  = !pool_r;
          ectl.wr_en  = pool_r;
          ictl.wr_val = setv_r;
          ectl.wr_val = setv_r;
          if (pool_r) begin
            efree_nxt = setv_r ? efree_r - 15'd1 : efree_r + 15'd1;
          end else begin
            ifree_nxt = setv_r ? ifree_r - 13'd1 : ifree_r + 13'd1;
          end
        end
        idx_nxt   = idx_r + (CW)'(1);
        state_nxt = cba_pkg::ST_RANGE_RD;
      end
      cba_pkg::ST_DONE: begin
        // hold until the output slot is free or being emptied
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {1'b0, efree_r[12:0], ifree_r[8:0], ok_r, addr_r};
          state_nxt  = cba_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cba_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  `CBA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n,
    in_tvalid && in_tready, state_r == cba_pkg::ST_IDLE, "item accepted while busy")
  `CBA_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped under stall")
  `CBA_ASSERT_IMPL(a_free_range, clk, rst_n,
    1'b1, ifree_r <= 13'(INT_BLOCKS) && efree_r <= 15'(EXT_BLOCKS), "free count out of range")
  `CBA_ASSERT_IMPL(a_ok_addr, clk, rst_n,
    out_tvalid && !out_tdata[16], out_tdata[15:0] == 16'd0, "failed alloc with address")

endmodule
